/* hw/rtl/kfd_pkg.sv */
// Shared constants, event codes and the close-request bundle for the KISS frame decoder.
package kfd_pkg;

  localparam int FRAME_BYTES_DEF = 512;
  localparam int SETHW_BYTES_DEF = 16;

  localparam logic [7:0] B_FEND      = 8'hC0;
  localparam logic [7:0] B_FESC      = 8'hDB;
  localparam logic [7:0] B_TFEND     = 8'hDC;
  localparam logic [7:0] B_TFESC     = 8'hDD;
  localparam logic [7:0] TYPE_RETURN = 8'hFF;
  localparam logic [3:0] PORT_RETURN = 4'hF;

  localparam logic [3:0] CMD_DATA      = 4'd0;
  localparam logic [3:0] CMD_TX_DELAY  = 4'd1;
  localparam logic [3:0] CMD_PERSIST   = 4'd2;
  localparam logic [3:0] CMD_SLOT_TIME = 4'd3;
  localparam logic [3:0] CMD_TX_TAIL   = 4'd4;
  localparam logic [3:0] CMD_DUPLEX    = 4'd5;
  localparam logic [3:0] CMD_SETHW     = 4'd6;

  localparam logic [7:0] TX_DELAY_RST  = 8'd50;
  localparam logic [7:0] PERSIST_RST   = 8'd63;
  localparam logic [7:0] SLOT_TIME_RST = 8'd10;
  localparam logic [7:0] TX_TAIL_RST   = 8'd0;

  typedef enum logic [2:0] {
    EV_NONE      = 3'd0,
    EV_PAYLOAD   = 3'd1,
    EV_DATA_END  = 3'd2,
    EV_OVERLEN   = 3'd3,
    EV_ESC_ERR   = 3'd4,
    EV_CMD_APPLY = 3'd5,
    EV_CMD_IGN   = 3'd6
  } kfd_ev_t;

  // Frame close request handed to the settings block.
  typedef struct packed {
    logic       close;
    logic [7:0] ftype;
    logic [7:0] first_payload;
  } kfd_close_t;

endpackage

/* hw/rtl/kiss_frame_decoder_core.sv */
// Top level of the KISS frame decoder: framing, unescape, payload stream and result register.
//
//   channel | ports                                   | direction | beat
//   --------+-----------------------------------------+-----------+---------------------------
//   in      | in_valid, in_ready, in_byte             | input     | one received KISS byte
//   out     | out_valid, out_ready, out_event_res ... | output    | one result per input byte
//
// Each input beat yields exactly one output beat in the cycle after it is accepted, held in
// the result register. Throughput is one byte per cycle while out_ready is high: decode is
// a single pass of compare-and-select logic from the frame state to the result register.
// Reset (rst_n low, synchronous) closes any frame, clears escape and drop state
// and loads the default settings: tx delay 50, persistence 63, slot time 10, tx tail 0, duplex off.
// While a result waits and out_ready is low, the result register holds and
// in_ready drops; input is taken again in the same cycle the held result is taken.
module kiss_frame_decoder_core import kfd_pkg::*; #(
  parameter int FRAME_BYTES = FRAME_BYTES_DEF,
  parameter int SETHW_BYTES = SETHW_BYTES_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_byte,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [2:0] out_event_res,
  output logic [7:0] out_data_byte,
  output logic [8:0] out_byte_index,
  output logic [3:0] out_port,
  output logic [8:0] out_frame_length,
  output logic [7:0] out_tx_delay,
  output logic [7:0] out_persistence,
  output logic [7:0] out_slot_time,
  output logic [7:0] out_tx_tail,
  output logic       out_full_duplex,
  output logic [4:0] out_hardware_length
);

  localparam int CNT_W = $clog2(FRAME_BYTES + 1);

  // Frame state
  logic             esc_r, esc_nxt;
  logic             drop_r, drop_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [7:0]       ftype_r, ftype_nxt;
  logic [7:0]       first_r, first_nxt;

  // Result register (settings and port are read straight from their state)
  logic             out_valid_r;
  kfd_ev_t          ev_r, ev_nxt;
  logic [7:0]       db_r, db_nxt;
  logic [8:0]       idx_r, idx_nxt;
  logic [8:0]       flen_r, flen_nxt;

  logic             in_fire;
  logic             closing;
  logic             take;
  logic [7:0]       byte_v;
  logic [CNT_W-1:0] pos;
  logic [CNT_W-1:0] plen;
  kfd_ev_t          close_ev;
  kfd_close_t       close_req;

  // Accept a new byte whenever the result slot is empty or being emptied.
  assign in_ready = !out_valid_r || out_ready;
  assign in_fire  = in_valid && in_ready;

  assign pos  = cnt_r - CNT_W'(1);
  assign plen = cnt_r - CNT_W'(1);

  always_comb begin
    esc_nxt   = esc_r;
    drop_nxt  = drop_r;
    cnt_nxt   = cnt_r;
    ftype_nxt = ftype_r;
    first_nxt = first_r;
    ev_nxt    = EV_NONE;
    db_nxt    = 8'd0;
    idx_nxt   = 9'd0;
    flen_nxt  = 9'd0;
    closing   = 1'b0;
    take      = 1'b0;
    byte_v    = in_byte;

    if (in_byte == B_FEND) begin
      // FEND: end a drop run, or close a frame that holds at least the type byte.
      if (drop_r) begin
        drop_nxt = 1'b0;
      end else if (cnt_r != '0) begin
        closing = 1'b1;
        ev_nxt  = close_ev;
        if (close_ev == EV_DATA_END) begin
          flen_nxt = 9'(plen);
        end
      end
      cnt_nxt = '0;
      esc_nxt = 1'b0;
    end else if (!drop_r) begin
      take = 1'b1;
      if (esc_r) begin
        if (in_byte == B_TFEND) begin
          byte_v = B_FEND;
        end else if (in_byte == B_TFESC) begin
          byte_v = B_FESC;
        end else begin
          // Bad escape: drop this byte.
          ev_nxt = EV_ESC_ERR;
          take   = 1'b0;
        end
        esc_nxt = 1'b0;
      end else if (in_byte == B_FESC) begin
        esc_nxt = 1'b1;
        take    = 1'b0;
      end
    end

    if (take) begin
      if (32'(cnt_r) >= 32'(FRAME_BYTES)) begin
        // Overlength: discard the frame and ignore bytes up to the next FEND.
        drop_nxt = 1'b1;
        cnt_nxt  = '0;
        esc_nxt  = 1'b0;
        ev_nxt   = EV_OVERLEN;
      end else begin
        if (cnt_r == '0) begin
          ftype_nxt = byte_v;
        end else begin
          if (ftype_r[3:0] == CMD_DATA) begin
            ev_nxt  = EV_PAYLOAD;
            db_nxt  = byte_v;
            idx_nxt = 9'(pos);
          end
          if (pos == '0) begin
            first_nxt = byte_v;
          end
        end
        cnt_nxt = cnt_r + CNT_W'(1);
      end
    end
  end

  assign close_req.close         = in_fire && closing;
  assign close_req.ftype         = ftype_r;
  assign close_req.first_payload = first_r;

  kfd_settings #(
    .FRAME_BYTES (FRAME_BYTES),
    .SETHW_BYTES (SETHW_BYTES)
  ) u_settings (
    .clk             (clk),
    .rst_n           (rst_n),
    .req             (close_req),
    .plen            (plen),
    .close_ev        (close_ev),
    .tx_delay        (out_tx_delay),
    .persistence     (out_persistence),
    .slot_time       (out_slot_time),
    .tx_tail         (out_tx_tail),
    .full_duplex     (out_full_duplex),
    .hardware_length (out_hardware_length)
  );

  // Frame control state: advance only on an accepted beat.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      esc_r   <= 1'b0;
      drop_r  <= 1'b0;
      cnt_r   <= '0;
      ftype_r <= 8'd0;
    end else if (in_fire) begin
      esc_r   <= esc_nxt;
      drop_r  <= drop_nxt;
      cnt_r   <= cnt_nxt;
      ftype_r <= ftype_nxt;
    end
  end

  // First payload byte; a close uses it only when the payload is non-empty.
  always_ff @(posedge clk) begin
    if (in_fire) begin
      first_r <= first_nxt;
    end
  end

  // Result register valid.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_fire) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  // Result payload: load on accept, hold otherwise.
  always_ff @(posedge clk) begin
    if (in_fire) begin
      ev_r   <= ev_nxt;
      db_r   <= db_nxt;
      idx_r  <= idx_nxt;
      flen_r <= flen_nxt;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_event_res    = ev_r;
  assign out_data_byte    = db_r;
  assign out_byte_index   = idx_r;
  assign out_frame_length = flen_r;
  assign out_port         = (ftype_r == TYPE_RETURN) ? PORT_RETURN : ftype_r[7:4];

endmodule

/* hw/rtl/kfd_settings.sv */
// TNC settings registers and the command decode done when a frame closes.
module kfd_settings import kfd_pkg::*; #(
  parameter int FRAME_BYTES = FRAME_BYTES_DEF,
  parameter int SETHW_BYTES = SETHW_BYTES_DEF,
  localparam int CNT_W = $clog2(FRAME_BYTES + 1),
  localparam int HW_W  = $clog2(SETHW_BYTES + 1)
) (
  input  logic             clk,
  input  logic             rst_n,
  input  kfd_close_t       req,
  input  logic [CNT_W-1:0] plen,
  output kfd_ev_t          close_ev,
  output logic [7:0]       tx_delay,
  output logic [7:0]       persistence,
  output logic [7:0]       slot_time,
  output logic [7:0]       tx_tail,
  output logic             full_duplex,
  output logic [4:0]       hardware_length
);

  logic [7:0]      tx_delay_r, tx_delay_nxt;
  logic [7:0]      persist_r, persist_nxt;
  logic [7:0]      slot_r, slot_nxt;
  logic [7:0]      tail_r, tail_nxt;
  logic            duplex_r, duplex_nxt;
  logic [HW_W-1:0] hw_len_r, hw_len_nxt;
  logic [HW_W-1:0] hw_cap;
  logic [3:0]      cmd;
  logic            plen_zero;

  assign cmd       = req.ftype[3:0];
  assign plen_zero = (plen == '0);

  // Stored set-hardware count is the payload length clipped to the store size.
  always_comb begin
    if (32'(plen) > 32'(SETHW_BYTES)) begin
      hw_cap = HW_W'(SETHW_BYTES);
    end else begin
      hw_cap = HW_W'(plen);
    end
  end

  always_comb begin
    close_ev     = EV_NONE;
    tx_delay_nxt = tx_delay_r;
    persist_nxt  = persist_r;
    slot_nxt     = slot_r;
    tail_nxt     = tail_r;
    duplex_nxt   = duplex_r;
    hw_len_nxt   = hw_len_r;
    if (req.ftype == TYPE_RETURN) begin
      close_ev = EV_NONE;
    end else begin
      unique case (cmd)
        CMD_DATA: begin
          close_ev = EV_DATA_END;
        end
        CMD_TX_DELAY, CMD_PERSIST, CMD_SLOT_TIME, CMD_TX_TAIL, CMD_DUPLEX: begin
          if (!plen_zero) begin
            close_ev = EV_CMD_APPLY;
            case (cmd)
              CMD_TX_DELAY:  tx_delay_nxt = req.first_payload;
              CMD_PERSIST:   persist_nxt  = req.first_payload;
              CMD_SLOT_TIME: slot_nxt     = req.first_payload;
              CMD_TX_TAIL:   tail_nxt     = req.first_payload;
              default:       duplex_nxt   = (req.first_payload != 8'd0);
            endcase
          end
        end
        CMD_SETHW: begin
          close_ev   = EV_CMD_APPLY;
          hw_len_nxt = hw_cap;
        end
        default: begin
          close_ev = EV_CMD_IGN;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tx_delay_r <= TX_DELAY_RST;
      persist_r  <= PERSIST_RST;
      slot_r     <= SLOT_TIME_RST;
      tail_r     <= TX_TAIL_RST;
      duplex_r   <= 1'b0;
      hw_len_r   <= '0;
    end else if (req.close) begin
      tx_delay_r <= tx_delay_nxt;
      persist_r  <= persist_nxt;
      slot_r     <= slot_nxt;
      tail_r     <= tail_nxt;
      duplex_r   <= duplex_nxt;
      hw_len_r   <= hw_len_nxt;
    end
  end

  assign tx_delay        = tx_delay_r;
  assign persistence     = persist_r;
  assign slot_time       = slot_r;
  assign tx_tail         = tail_r;
  assign full_duplex     = duplex_r;
  assign hardware_length = 5'(hw_len_r);

endmodule
